### sv/bcd_alu_pkg.sv
// ----------------------------------------------------------------------------
// BCD ALU package
// Shared widths, operation codes, status codes and controller states.
// ----------------------------------------------------------------------------
package bcd_alu_pkg;

  localparam int unsigned DIGITS_DEF = 16;
  localparam int unsigned OPND_W     = 64;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CMP_W      = 2;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  localparam logic signed [CMP_W-1:0] CMP_LT = 2'sb11;
  localparam logic signed [CMP_W-1:0] CMP_EQ = 2'sb00;
  localparam logic signed [CMP_W-1:0] CMP_GT = 2'sb01;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PASS,
    S_FINISH
  } state_e;

endpackage

### sv/bcd_alu_req_if.sv
// ----------------------------------------------------------------------------
// BCD ALU request channel
// Valid/ready channel carrying the operation and both packed BCD operands.
// ----------------------------------------------------------------------------
interface bcd_alu_req_if import bcd_alu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [OPND_W-1:0] operand_a;
  logic [OPND_W-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input req_type, input operand_a, input operand_b,
                  output ready);
endinterface

### sv/bcd_alu_rsp_if.sv
// ----------------------------------------------------------------------------
// BCD ALU response channel
// Valid/ready channel carrying the result value, compare code and status.
// ----------------------------------------------------------------------------
interface bcd_alu_rsp_if import bcd_alu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OPND_W-1:0]       result_value;
  logic signed [CMP_W-1:0] compare_result;
  logic [STAT_W-1:0]       status;

  modport source (output valid, output result_value, output compare_result,
                  output status, input ready);
  modport sink   (input valid, input result_value, input compare_result,
                  input status, output ready);
endinterface

### sv/bcd_decimal_alu.sv
// ----------------------------------------------------------------------------
// BCD decimal ALU
// Unsigned packed-BCD add, subtract, multiply, divide and compare, computed
// one decimal digit per cycle through nibble shift registers.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | transaction
//  req_i   | in  | req_type, operand_a, operand_b            | valid & ready
//  rsp_o   | out | result_value, compare_result, status      | valid & ready
//
//  Add, subtract, compare: one serial pass of DIGITS+1 digits.
//  Multiply: one shift plus one pass per digit of b.
//  Divide: each quotient digit takes one shift to bring down a dividend digit,
//  then one trial-subtract pass per unit of the digit plus one failing pass.
//  One transaction is in flight at a time; the result register lets the next
//  request enter while a result waits. Reset clears control only.
// ----------------------------------------------------------------------------
module bcd_decimal_alu import bcd_alu_pkg::*; #(
  parameter int unsigned DIGITS = DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bcd_alu_req_if.sink   req_i,
  bcd_alu_rsp_if.source rsp_o
);

  localparam int unsigned DW  = DIGITS * 4;
  localparam int unsigned AW  = DW + 4;
  localparam int unsigned CW  = $clog2(DIGITS + 1);
  localparam int unsigned DCW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [DW-1:0]     a_q, a_d, b_q, b_d;
  logic [AW-1:0]     acc_q, acc_d, tmp_q, tmp_d;
  logic [3:0]        c_q, c_d, m_q, m_d, qd_q, qd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DCW-1:0]    dcnt_q, dcnt_d;
  logic              ovf_q, ovf_d, nz_q, nz_d, bz_q, bz_d;
  logic              rv_q, rv_d;
  logic [OPND_W-1:0] res_q, res_d;
  logic [CMP_W-1:0]  cmp_q, cmp_d;
  logic [STAT_W-1:0] st_q, st_d;

  logic [DW-1:0] a_clean, b_clean;

  for (genvar i = 0; i < DIGITS; i++) begin : g_clean
    assign a_clean[4*i +: 4] = (req_i.operand_a[4*i +: 4] > 4'd9) ? 4'd0
                                                                 : req_i.operand_a[4*i +: 4];
    assign b_clean[4*i +: 4] = (req_i.operand_b[4*i +: 4] > 4'd9) ? 4'd0
                                                                 : req_i.operand_b[4*i +: 4];
  end

  // serial digit unit
  logic        last, in_rng, sub_mode, round_last, out_free, neg;
  logic [3:0]  a_dig, b_dig, x, dig, dig_add, dig_sub, cq, cout;
  logic [6:0]  p7, s7;
  logic [14:0] m15;
  logic [4:0]  ds;
  logic [DW-1:0] a_rot, b_rot;

  assign last       = (cnt_q == CW'(DIGITS));
  assign in_rng     = !last;
  assign round_last = (dcnt_q == DCW'(DIGITS - 1));
  assign out_free   = !rv_q || rsp_o.ready;
  assign a_dig      = in_rng ? a_q[3:0] : 4'd0;
  assign b_dig      = in_rng ? b_q[3:0] : 4'd0;
  assign sub_mode   = (op_q == OP_SUB) || (op_q == OP_CMP) || (op_q == OP_DIV);
  assign x          = ((op_q == OP_MUL) || (op_q == OP_DIV)) ? acc_q[3:0] : a_dig;
  assign p7         = (op_q == OP_MUL) ? 7'(a_dig * m_q) : {3'd0, b_dig};
  assign s7         = {3'd0, x} + p7 + {3'd0, c_q};
  // divide by ten through the reciprocal, exact below 160, which covers every 7-bit sum
  assign m15        = 15'(s7) * 15'd205;
  assign cq         = m15[14:11];
  assign dig_add    = 4'(s7 - 7'(cq) * 7'd10);
  assign ds         = {1'b0, x} - {1'b0, b_dig} - {4'd0, c_q[0]};
  assign neg        = ds[4];
  assign dig_sub    = neg ? 4'(ds + 5'd10) : ds[3:0];
  assign dig        = sub_mode ? dig_sub : dig_add;
  assign cout       = sub_mode ? {3'd0, neg} : cq;
  assign a_rot      = (a_q >> 4) | (DW'(a_q[3:0]) << (DW - 4));
  assign b_rot      = (b_q >> 4) | (DW'(b_q[3:0]) << (DW - 4));

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rv_q;
  assign rsp_o.result_value   = res_q;
  assign rsp_o.compare_result = cmp_q;
  assign rsp_o.status         = st_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          case (req_i.req_type)
            OP_ADD, OP_SUB, OP_CMP: state_d = S_PASS;
            OP_MUL:                 state_d = S_SHIFT;
            OP_DIV:                 state_d = (b_clean == '0) ? S_FINISH : S_SHIFT;
            default:                state_d = S_FINISH;
          endcase
        end
      end
      S_SHIFT: state_d = S_PASS;
      S_PASS: begin
        if (last) begin
          case (op_q)
            OP_MUL:  state_d = round_last ? S_FINISH : S_SHIFT;
            OP_DIV:  state_d = !neg ? S_PASS : (round_last ? S_FINISH : S_SHIFT);
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_FINISH: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    op_d   = op_q;   a_d   = a_q;   b_d   = b_q;   acc_d = acc_q; tmp_d = tmp_q;
    c_d    = c_q;    m_d   = m_q;   qd_d  = qd_q;  cnt_d = cnt_q; dcnt_d = dcnt_q;
    ovf_d  = ovf_q;  nz_d  = nz_q;  bz_d  = bz_q;
    rv_d   = rv_q & ~rsp_o.ready;
    res_d  = res_q;  cmp_d = cmp_q; st_d  = st_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d   = op_e'(req_i.req_type);
          a_d    = a_clean;
          b_d    = b_clean;
          acc_d  = '0;
          tmp_d  = '0;
          c_d    = '0;
          qd_d   = '0;
          cnt_d  = '0;
          dcnt_d = '0;
          ovf_d  = 1'b0;
          nz_d   = 1'b0;
          bz_d   = (b_clean == '0);
        end
      end
      S_SHIFT: begin
        cnt_d = '0;
        c_d   = '0;
        qd_d  = '0;
        if (op_q == OP_MUL) begin
          ovf_d = ovf_q | (acc_q[AW-1 -: 8] != 8'd0);
          acc_d = acc_q << 4;
          m_d   = b_q[DW-1 -: 4];
          b_d   = (b_q << 4) | DW'(b_q[DW-1 -: 4]);
        end else begin
          // bring down the next dividend digit
          acc_d = (acc_q << 4) | AW'(a_q[DW-1 -: 4]);
          a_d   = a_q << 4;
        end
      end
      S_PASS: begin
        cnt_d = cnt_q + CW'(1);
        c_d   = cout;
        case (op_q)
          OP_MUL: begin
            acc_d = {dig, acc_q[AW-1:4]};
            if (in_rng) a_d = a_rot;
          end
          OP_DIV: begin
            tmp_d = {dig, tmp_q[AW-1:4]};
            acc_d = {acc_q[3:0], acc_q[AW-1:4]};
            if (in_rng) b_d = b_rot;
          end
          default: begin
            acc_d = {dig, acc_q[AW-1:4]};
            nz_d  = nz_q | (dig != 4'd0);
            if (in_rng) begin
              a_d = a_rot;
              b_d = b_rot;
            end
          end
        endcase
        if (last) begin
          cnt_d = '0;
          if (op_q == OP_MUL) begin
            c_d    = '0;
            ovf_d  = ovf_q | (cout != 4'd0);
            dcnt_d = dcnt_q + DCW'(1);
          end else if (op_q == OP_DIV) begin
            c_d = '0;
            if (!neg) begin
              // trial fits: keep the difference, count the quotient digit
              acc_d = {dig, tmp_q[AW-1:4]};
              qd_d  = qd_q + 4'd1;
            end else begin
              a_d    = a_q | DW'(qd_q);
              dcnt_d = dcnt_q + DCW'(1);
            end
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          rv_d  = 1'b1;
          res_d = '0;
          cmp_d = CMP_EQ;
          st_d  = ST_OK;
          case (op_q)
            OP_ADD: begin
              if (acc_q[AW-1 -: 4] != 4'd0) st_d  = ST_OVERFLOW;
              else                          res_d = OPND_W'(acc_q[DW-1:0]);
            end
            OP_SUB: begin
              if (c_q[0]) st_d  = ST_UNDERFLOW;
              else        res_d = OPND_W'(acc_q[DW-1:0]);
            end
            OP_MUL: begin
              if (ovf_q || (acc_q[AW-1 -: 4] != 4'd0)) st_d  = ST_OVERFLOW;
              else                                     res_d = OPND_W'(acc_q[DW-1:0]);
            end
            OP_DIV: begin
              if (bz_q) st_d  = ST_DIVZERO;
              else      res_d = OPND_W'(a_q);
            end
            OP_CMP: begin
              if (c_q[0])    cmp_d = CMP_LT;
              else if (nz_q) cmp_d = CMP_GT;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;   a_q   <= a_d;   b_q   <= b_d;   acc_q <= acc_d; tmp_q <= tmp_d;
    c_q    <= c_d;    m_q   <= m_d;   qd_q  <= qd_d;  cnt_q <= cnt_d; dcnt_q <= dcnt_d;
    ovf_q  <= ovf_d;  nz_q  <= nz_d;  bz_q  <= bz_d;
    res_q  <= res_d;  cmp_q <= cmp_d; st_q  <= st_d;
  end

endmodule

### sv/bcd_alu_chk.sv
// ----------------------------------------------------------------------------
// BCD ALU port checker
// Watches the request and response channels of the ALU top level.
// ----------------------------------------------------------------------------
module bcd_alu_chk import bcd_alu_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [OPND_W-1:0]       rsp_value_i,
  input logic signed [CMP_W-1:0] rsp_cmp_i,
  input logic [STAT_W-1:0]       rsp_status_i
);

  // one transaction at a time: accepting closes the request side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while a transaction is in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != ST_OK)) |-> (rsp_value_i == '0) && (rsp_cmp_i == CMP_EQ))
    else $error("error result carries a nonzero value");

  a_cmp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_cmp_i != CMP_EQ)) |->
      ((rsp_cmp_i == CMP_LT) || (rsp_cmp_i == CMP_GT)) && (rsp_value_i == '0))
    else $error("bad compare code");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i && $stable(rsp_value_i)
                                      && $stable(rsp_status_i) && $stable(rsp_cmp_i))
    else $error("stalled response changed");

endmodule

bind bcd_decimal_alu bcd_alu_chk u_bcd_alu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_value_i  (rsp_o.result_value),
  .rsp_cmp_i    (rsp_o.compare_result),
  .rsp_status_i (rsp_o.status)
);
